// ===== rtl/core/buddy_page_allocator_defines.svh =====
// Assertion macros for the buddy page allocator RTL.
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define BPA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define BPA_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BPA_ASSERT(name, prop, msg)
`define BPA_ASSERT_NEVER(name, cond, msg)
`endif
`endif

// ===== rtl/core/bpa_pkg.sv =====
// Types, constants and command encodings of the buddy page allocator.
package bpa_pkg;

  localparam int unsigned TOP_ORDER     = 10;
  localparam int unsigned NUM_ORD       = TOP_ORDER + 1;
  localparam int unsigned STORE_ENTRIES = 2048;
  localparam int unsigned STORE_AW      = $clog2(STORE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(STORE_ENTRIES + 1);
  localparam int unsigned ORD_W         = $clog2(TOP_ORDER + 2);
  localparam int unsigned PAGE_SHIFT    = 12;
  localparam int unsigned PAGE_W        = 32 - PAGE_SHIFT;
  localparam int unsigned FREE_W        = 12;
  localparam int unsigned LARGE_W       = 11;
  localparam int unsigned FREE_SAT      = 4095;
  localparam int unsigned LARGE_SAT     = 2047;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    FN_INIT  = 2'd0,
    FN_ALLOC = 2'd1,
    FN_FREE  = 2'd2,
    FN_NOP   = 2'd3
  } func_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ORDER = 3'd1,
    ST_NO_BLOCK  = 3'd2,
    ST_REJECT    = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_START = 1'b0,
    REG_END   = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] block_address;
    logic [4:0]  block_order;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_address;
    logic [11:0] pages_free;
    logic [10:0] largest_free_pages;
    logic [11:0] count_at_order;
  } rsp_t;

  // Datapath micro-operations.
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLEAR,
    DP_SCAN_STEP,
    DP_SEED_NEXT,
    DP_SEED_TAKE,
    DP_PUSH_SETUP,
    DP_PUSH_RD,
    DP_PUSH_WR,
    DP_PUSH_PUT,
    DP_POP_POS,
    DP_READ,
    DP_GRAB,
    DP_RM_RD,
    DP_RM_WR,
    DP_RM_DONE,
    DP_GRANT,
    DP_NO_BLOCK,
    DP_O_INC,
    DP_O_DEC,
    DP_SET_OK,
    DP_HALF_TAKE,
    DP_BAD_ORDER,
    DP_REJECT,
    DP_FIND_START,
    DP_FIND_POS,
    DP_FIND_DEC,
    DP_MERGE,
    DP_FREE_TAKE,
    DP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   scan_start;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  scan_last;
    logic  ord_bad;
    logic  len_nz;
    logic  o_top;
    logic  o_gt_top;
    logic  o_eq_ord;
    logic  o_zero;
    logic  full;
    logic  ptr_at_pos;
    logic  rm_end;
    logic  seed_fit;
    logic  seed_in;
    logic  free_ok;
    logic  bud_in;
    logic  half_in;
    logic  fcnt_zero;
    logic  hit;
    logic  out_busy;
  } dp_sts_t;

endpackage

// ===== rtl/core/bpa_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register one read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/bpa_dp.sv =====
// Datapath: list lengths, free block store, address arithmetic, result register.
`include "buddy_page_allocator_defines.svh"
module bpa_dp import bpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  req_t        req_i,
  input  logic [31:0] region_start_i,
  input  logic [31:0] region_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_data_o
);

  func_e                func_q;
  logic [4:0]           ord_q;
  logic [31:0]          addr_q;
  logic [ORD_W-1:0]     o_q;
  status_e              status_q;
  logic [31:0]          granted_q;
  logic [CNT_W-1:0]     len_q [NUM_ORD];
  logic [ORD_W-1:0]     k_q;
  logic [CNT_W-1:0]     base_q, used_q, cur_len_q, cnt_q, ptr_q, fcnt_q;
  logic [FREE_W-1:0]    pages_q;
  logic [LARGE_W-1:0]   largest_q;
  logic [PAGE_W-1:0]    page_q;
  logic                 out_valid_q;
  rsp_t                 out_q;

  logic                 ram_we;
  logic [STORE_AW-1:0]  ram_waddr, ram_raddr;
  logic [PAGE_W-1:0]    ram_wdata, ram_rdata;

  logic [2**ORD_W-1:0]  ne;
  logic [CNT_W-1:0]     len_k, ptr_m1, ptr_p1, pos_push;
  logic [31:0]          size32, half, bud;
  logic [33:0]          bs, al;
  logic [FREE_W+CNT_W+TOP_ORDER-1:0]  term, psum;
  logic [LARGE_W+TOP_ORDER-1:0]       one_k;

  function automatic logic in_region(logic [31:0] a, logic [31:0] s, logic [31:0] e);
    return (a >= s) && (a < e);
  endfunction

  // Nonempty flags, padded so any order code indexes safely.
  always_comb begin
    ne = '0;
    for (int i = 0; i < NUM_ORD; i++) begin
      ne[i] = (len_q[i] != '0);
    end
  end

  assign len_k    = len_q[k_q];
  assign ptr_m1   = ptr_q - CNT_W'(1);
  assign ptr_p1   = ptr_q + CNT_W'(1);
  assign pos_push = base_q + cur_len_q;
  assign size32   = 32'(1) << (o_q + PAGE_SHIFT);
  assign half     = addr_q + size32;
  assign bud      = addr_q ^ size32;
  assign bs       = 34'(1) << (o_q + PAGE_SHIFT);
  assign al       = (34'(region_start_i) + bs - 34'd1) & ~(bs - 34'd1);
  assign term     = (FREE_W+CNT_W+TOP_ORDER)'(len_k) << k_q;
  assign psum     = term + (FREE_W+CNT_W+TOP_ORDER)'(pages_q);
  assign one_k    = (LARGE_W+TOP_ORDER)'(1) << k_q;

  // Status toward the controller.
  always_comb begin
    sts_o.func       = func_q;
    sts_o.scan_last  = (k_q == ORD_W'(TOP_ORDER));
    sts_o.ord_bad    = (ord_q > 5'(TOP_ORDER));
    sts_o.len_nz     = ne[o_q];
    sts_o.o_top      = (o_q == ORD_W'(TOP_ORDER));
    sts_o.o_gt_top   = (o_q > ORD_W'(TOP_ORDER));
    sts_o.o_eq_ord   = (5'(o_q) == ord_q);
    sts_o.o_zero     = (o_q == '0);
    sts_o.full       = (used_q >= CNT_W'(STORE_ENTRIES));
    sts_o.ptr_at_pos = (ptr_q == pos_push);
    sts_o.rm_end     = (ptr_p1 >= used_q);
    sts_o.seed_fit   = ((al + bs) <= 34'(region_end_i));
    sts_o.seed_in    = (al < 34'(region_end_i));
    sts_o.free_ok    = in_region(addr_q, region_start_i, region_end_i)
                       && ((addr_q & (size32 - 32'd1)) == '0);
    sts_o.bud_in     = in_region(bud, region_start_i, region_end_i);
    sts_o.half_in    = in_region(half, region_start_i, region_end_i);
    sts_o.fcnt_zero  = (fcnt_q == '0);
    sts_o.hit        = (ram_rdata == bud[31:PAGE_SHIFT]);
    sts_o.out_busy   = out_valid_q && out_stall_i;
  end

  // Store port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q[STORE_AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = ptr_q[STORE_AW-1:0];
    case (cmd_i.op)
      DP_PUSH_RD:  ram_raddr = ptr_m1[STORE_AW-1:0];
      DP_RM_RD:    ram_raddr = ptr_p1[STORE_AW-1:0];
      DP_PUSH_WR:  ram_we = 1'b1;
      DP_RM_WR:    ram_we = 1'b1;
      DP_PUSH_PUT: begin
        ram_we    = 1'b1;
        ram_wdata = page_q;
      end
      default: ;
    endcase
  end

  bpa_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (STORE_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // List lengths and result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ORD; i++) begin
        len_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == DP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        DP_CLEAR: begin
          for (int i = 0; i < NUM_ORD; i++) begin
            len_q[i] <= '0;
          end
        end
        DP_PUSH_PUT: len_q[o_q] <= len_q[o_q] + CNT_W'(1);
        DP_RM_DONE:  len_q[o_q] <= len_q[o_q] - CNT_W'(1);
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        func_q    <= func_e'(req_i.func);
        ord_q     <= req_i.block_order;
        addr_q    <= req_i.block_address;
        o_q       <= req_i.block_order[ORD_W-1:0];
        status_q  <= ST_OK;
        granted_q <= '0;
      end
      DP_CLEAR:      o_q <= ORD_W'(TOP_ORDER);
      DP_SCAN_STEP: begin
        k_q    <= k_q + ORD_W'(1);
        used_q <= used_q + len_k;
        if (k_q < o_q) begin
          base_q <= base_q + len_k;
        end
        if (k_q == o_q) begin
          cur_len_q <= len_k;
        end
        if (5'(k_q) == ord_q) begin
          cnt_q <= len_k;
        end
        pages_q <= (psum > (FREE_W+CNT_W+TOP_ORDER)'(FREE_SAT)) ? FREE_W'(FREE_SAT)
                                                                 : psum[FREE_W-1:0];
        if (len_k != '0) begin
          largest_q <= (one_k > (LARGE_W+TOP_ORDER)'(LARGE_SAT)) ? LARGE_W'(LARGE_SAT)
                                                                  : one_k[LARGE_W-1:0];
        end
      end
      DP_SEED_NEXT:  o_q <= o_q - ORD_W'(1);
      DP_SEED_TAKE:  page_q <= al[31:PAGE_SHIFT];
      DP_PUSH_SETUP: begin
        ptr_q <= used_q;
        if (used_q >= CNT_W'(STORE_ENTRIES)) begin
          status_q <= ST_FULL;
        end
      end
      DP_PUSH_WR:    ptr_q <= ptr_m1;
      DP_POP_POS:    ptr_q <= base_q + cur_len_q - CNT_W'(1);
      DP_GRAB:       addr_q <= {ram_rdata, PAGE_SHIFT'(0)};
      DP_RM_WR:      ptr_q <= ptr_p1;
      DP_GRANT:      granted_q <= addr_q;
      DP_NO_BLOCK: begin
        status_q <= ST_NO_BLOCK;
        o_q      <= o_q + ORD_W'(1);
      end
      DP_O_INC:      o_q <= o_q + ORD_W'(1);
      DP_O_DEC:      o_q <= o_q - ORD_W'(1);
      DP_SET_OK:     status_q <= ST_OK;
      DP_HALF_TAKE:  page_q <= half[31:PAGE_SHIFT];
      DP_BAD_ORDER:  status_q <= ST_BAD_ORDER;
      DP_REJECT:     status_q <= ST_REJECT;
      DP_FIND_START: fcnt_q <= cur_len_q;
      DP_FIND_POS:   ptr_q <= base_q + fcnt_q - CNT_W'(1);
      DP_FIND_DEC:   fcnt_q <= fcnt_q - CNT_W'(1);
      DP_MERGE: begin
        addr_q <= addr_q & ~size32;
        o_q    <= o_q + ORD_W'(1);
      end
      DP_FREE_TAKE:  page_q <= addr_q[31:PAGE_SHIFT];
      DP_RESULT: begin
        out_q.status             <= status_q;
        out_q.granted_address    <= granted_q;
        out_q.pages_free         <= pages_q;
        out_q.largest_free_pages <= largest_q;
        out_q.count_at_order     <= cnt_q;
      end
      default: ;
    endcase
    // Restart the length scan.
    if (cmd_i.scan_start) begin
      k_q       <= '0;
      base_q    <= '0;
      used_q    <= '0;
      cur_len_q <= '0;
      cnt_q     <= '0;
      pages_q   <= '0;
      largest_q <= '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BPA_ASSERT(a_put_room, (cmd_i.op == DP_PUSH_PUT) |-> (used_q < CNT_W'(STORE_ENTRIES)), "push into full store")
  `BPA_ASSERT(a_rm_bound, (cmd_i.op == DP_RM_WR) |-> (ptr_p1 < used_q), "remove shift past end")
  `BPA_ASSERT(a_len_dec, (cmd_i.op == DP_RM_DONE) |-> ne[o_q], "remove from empty list")
  `BPA_ASSERT_NEVER(a_result_busy, (cmd_i.op == DP_RESULT) && out_valid_q && out_stall_i, "result overwrite")

endmodule

// ===== rtl/core/bpa_ctrl.sv =====
// Controller: sequences scans, pushes, pops, searches and merges.
module bpa_ctrl import bpa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [24:0] {
    S_IDLE       = 25'd1 << 0,
    S_DISPATCH   = 25'd1 << 1,
    S_SEED       = 25'd1 << 2,
    S_SEARCH     = 25'd1 << 3,
    S_SPLIT_DEC  = 25'd1 << 4,
    S_SPLIT_CHK  = 25'd1 << 5,
    S_GRANT      = 25'd1 << 6,
    S_MERGE      = 25'd1 << 7,
    S_FIND       = 25'd1 << 8,
    S_FIND_POS   = 25'd1 << 9,
    S_FIND_RD    = 25'd1 << 10,
    S_FIND_CMP   = 25'd1 << 11,
    S_MERGE_UPD  = 25'd1 << 12,
    S_FREE_PUSH  = 25'd1 << 13,
    S_SCAN       = 25'd1 << 14,
    S_PUSH       = 25'd1 << 15,
    S_PUSH_SHIFT = 25'd1 << 16,
    S_PUSH_WR    = 25'd1 << 17,
    S_POP        = 25'd1 << 18,
    S_POP_RD     = 25'd1 << 19,
    S_POP_GRAB   = 25'd1 << 20,
    S_RM         = 25'd1 << 21,
    S_RM_WR      = 25'd1 << 22,
    S_SUM        = 25'd1 << 23,
    S_RESULT     = 25'd1 << 24
  } state_e;

  state_e state_q, state_d, scan_ret_q, scan_ret_d, ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scan_ret_q <= S_IDLE;
      ret_q      <= S_IDLE;
    end else begin
      state_q    <= state_d;
      scan_ret_q <= scan_ret_d;
      ret_q      <= ret_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_d          = state_q;
    scan_ret_d       = scan_ret_q;
    ret_d            = ret_q;
    cmd_o.op         = DP_NOP;
    cmd_o.scan_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.func)
          FN_INIT: begin
            cmd_o.op = DP_CLEAR;
            state_d  = S_SEED;
          end
          FN_ALLOC: begin
            if (sts_i.ord_bad) begin
              cmd_o.op = DP_BAD_ORDER;
              state_d  = S_SUM;
            end else if (sts_i.len_nz) begin
              cmd_o.scan_start = 1'b1;
              scan_ret_d       = S_POP;
              ret_d            = S_GRANT;
              state_d          = S_SCAN;
            end else begin
              cmd_o.op = DP_NO_BLOCK;
              state_d  = S_SEARCH;
            end
          end
          FN_FREE: begin
            if (sts_i.ord_bad) begin
              cmd_o.op = DP_BAD_ORDER;
              state_d  = S_SUM;
            end else if (!sts_i.free_ok) begin
              cmd_o.op = DP_REJECT;
              state_d  = S_SUM;
            end else begin
              state_d = S_MERGE;
            end
          end
          default: state_d = S_SUM;
        endcase
      end
      // Walk orders down until an aligned block fits or order zero is reached.
      S_SEED: begin
        if (sts_i.seed_fit) begin
          if (sts_i.seed_in) begin
            cmd_o.op         = DP_SEED_TAKE;
            cmd_o.scan_start = 1'b1;
            scan_ret_d       = S_PUSH;
            ret_d            = S_SUM;
            state_d          = S_SCAN;
          end else begin
            state_d = S_SUM;
          end
        end else if (sts_i.o_zero) begin
          state_d = S_SUM;
        end else begin
          cmd_o.op = DP_SEED_NEXT;
        end
      end
      // Find the nearest higher nonempty order.
      S_SEARCH: begin
        if (sts_i.o_gt_top) begin
          state_d = S_SUM;
        end else if (sts_i.len_nz) begin
          cmd_o.op         = DP_SET_OK;
          cmd_o.scan_start = 1'b1;
          scan_ret_d       = S_POP;
          ret_d            = S_SPLIT_DEC;
          state_d          = S_SCAN;
        end else begin
          cmd_o.op = DP_O_INC;
        end
      end
      S_SPLIT_DEC: begin
        if (sts_i.o_eq_ord) begin
          state_d = S_GRANT;
        end else begin
          cmd_o.op = DP_O_DEC;
          state_d  = S_SPLIT_CHK;
        end
      end
      S_SPLIT_CHK: begin
        if (sts_i.half_in) begin
          cmd_o.op         = DP_HALF_TAKE;
          cmd_o.scan_start = 1'b1;
          scan_ret_d       = S_PUSH;
          ret_d            = S_SPLIT_DEC;
          state_d          = S_SCAN;
        end else begin
          state_d = S_SPLIT_DEC;
        end
      end
      S_GRANT: begin
        cmd_o.op = DP_GRANT;
        state_d  = S_SUM;
      end
      // Merge with free buddies.
      S_MERGE: begin
        if (sts_i.o_top || !sts_i.bud_in) begin
          state_d = S_FREE_PUSH;
        end else begin
          cmd_o.scan_start = 1'b1;
          scan_ret_d       = S_FIND;
          state_d          = S_SCAN;
        end
      end
      S_FIND: begin
        cmd_o.op = DP_FIND_START;
        state_d  = S_FIND_POS;
      end
      S_FIND_POS: begin
        if (sts_i.fcnt_zero) begin
          state_d = S_FREE_PUSH;
        end else begin
          cmd_o.op = DP_FIND_POS;
          state_d  = S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        cmd_o.op = DP_READ;
        state_d  = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (sts_i.hit) begin
          ret_d   = S_MERGE_UPD;
          state_d = S_RM;
        end else begin
          cmd_o.op = DP_FIND_DEC;
          state_d  = S_FIND_POS;
        end
      end
      S_MERGE_UPD: begin
        cmd_o.op = DP_MERGE;
        state_d  = S_MERGE;
      end
      S_FREE_PUSH: begin
        cmd_o.op         = DP_FREE_TAKE;
        cmd_o.scan_start = 1'b1;
        scan_ret_d       = S_PUSH;
        ret_d            = S_SUM;
        state_d          = S_SCAN;
      end
      // Accumulate list lengths one order per cycle.
      S_SCAN: begin
        cmd_o.op = DP_SCAN_STEP;
        if (sts_i.scan_last) begin
          state_d = scan_ret_q;
        end
      end
      // Insert at the top of the list, shifting later entries up.
      S_PUSH: begin
        cmd_o.op = DP_PUSH_SETUP;
        state_d  = sts_i.full ? ret_q : S_PUSH_SHIFT;
      end
      S_PUSH_SHIFT: begin
        if (sts_i.ptr_at_pos) begin
          cmd_o.op = DP_PUSH_PUT;
          state_d  = ret_q;
        end else begin
          cmd_o.op = DP_PUSH_RD;
          state_d  = S_PUSH_WR;
        end
      end
      S_PUSH_WR: begin
        cmd_o.op = DP_PUSH_WR;
        state_d  = S_PUSH_SHIFT;
      end
      // Take the newest entry of the list.
      S_POP: begin
        cmd_o.op = DP_POP_POS;
        state_d  = S_POP_RD;
      end
      S_POP_RD: begin
        cmd_o.op = DP_READ;
        state_d  = S_POP_GRAB;
      end
      S_POP_GRAB: begin
        cmd_o.op = DP_GRAB;
        state_d  = S_RM;
      end
      // Close the gap, shifting later entries down.
      S_RM: begin
        if (sts_i.rm_end) begin
          cmd_o.op = DP_RM_DONE;
          state_d  = ret_q;
        end else begin
          cmd_o.op = DP_RM_RD;
          state_d  = S_RM_WR;
        end
      end
      S_RM_WR: begin
        cmd_o.op = DP_RM_WR;
        state_d  = S_RM;
      end
      S_SUM: begin
        cmd_o.scan_start = 1'b1;
        scan_ret_d       = S_RESULT;
        state_d          = S_SCAN;
      end
      // Hold until the result register is free.
      S_RESULT: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = DP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/buddy_page_allocator.sv =====
// Buddy page allocator top level: configuration registers, controller and datapath.
//
// Usage: configure region_start (byte 0) and region_end (byte 4) over the APB
// port, then send an init beat. Allocate and free beats follow on the input
// channel (in_valid_i / in_stall_o); one result beat per input beat leaves on
// the output channel (out_valid_o / out_stall_i).
// One item is processed at a time. Each pass over the list lengths visits every
// order; inserting into or removing from the packed free block store moves
// every later entry, one by one through the store's single read and write
// port. A splitting allocate or a merging free adds one scan and one shift
// per order visited, and a merging free also walks each visited list.
// The input is stalled while an item is at work; the result register holds
// its beat under out_stall_i while the next item is accepted and worked on.
// Reset empties all lists and clears the region registers; the store itself
// needs no clearing pass.
module buddy_page_allocator import bpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] region_start_q, region_end_q;
  logic        cfg_we;
  reg_e        cfg_idx;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[2]);

  // Write region registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= '0;
      region_end_q   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_START: region_start_q <= pwdata;
        REG_END:   region_end_q   <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back region registers.
  always_comb begin
    case (cfg_idx)
      REG_START: prdata = region_start_q;
      REG_END:   prdata = region_end_q;
      default:   prdata = '0;
    endcase
  end

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bpa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_i          (in_data_i),
    .region_start_i (region_start_q),
    .region_end_i   (region_end_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule
